// ----- rtl/acs_pkg.sv -----
package acs_pkg;

  localparam logic [1:0] FUNC_MODE    = 2'd0;
  localparam logic [1:0] FUNC_UP      = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  localparam logic [3:0] MODE_VIEW_YEAR    = 4'd0;
  localparam logic [3:0] MODE_VIEW_DATE    = 4'd1;
  localparam logic [3:0] MODE_VIEW_TIME    = 4'd2;
  localparam logic [3:0] MODE_SET_YEAR     = 4'd3;
  localparam logic [3:0] MODE_SET_MONTH    = 4'd4;
  localparam logic [3:0] MODE_SET_DATE     = 4'd5;
  localparam logic [3:0] MODE_SET_HOUR     = 4'd6;
  localparam logic [3:0] MODE_SET_MINUTE   = 4'd7;
  localparam logic [3:0] MODE_SET_AL_HOUR  = 4'd8;
  localparam logic [3:0] MODE_SET_AL_MIN   = 4'd9;
  localparam logic [3:0] MODE_SET_LEVEL    = 4'd10;

  typedef enum logic [0:0] {
    REG_DEBOUNCE = 1'b0,
    REG_BLINK    = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] DEBOUNCE_RST  = 16'd200;
  localparam logic [15:0] BLINK_RST     = 16'd700;
  localparam logic [11:0] YEAR_RST      = 12'd2025;
  localparam logic [3:0]  MONTH_RST     = 4'd6;
  localparam logic [4:0]  DATE_RST      = 5'd3;
  localparam logic [4:0]  HOUR_RST      = 5'd21;
  localparam logic [5:0]  MINUTE_RST    = 6'd33;
  localparam logic [4:0]  AL_HOUR_RST   = 5'd10;
  localparam logic [5:0]  AL_MINUTE_RST = 6'd20;
  localparam logic [2:0]  LEVEL_RST     = 3'd7;
  localparam logic [11:0] YEAR_MAX      = 12'd2099;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] DOT_BIT    = 8'h80;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] time_ms;
    logic [11:0] clock_year;
    logic [3:0]  clock_month;
    logic [4:0]  clock_date;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  char0;
    logic [7:0]  char1;
    logic [7:0]  char2;
    logic [7:0]  char3;
    logic        buzz;
    logic        commit;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_date;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [2:0]  out_brightness;
  } out_word_t;

  // reciprocal multiplies, exact for 12-bit inputs
  function automatic logic [8:0] div10(input logic [11:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd3277;
    return p[23:15];
  endfunction

  function automatic logic [6:0] div100(input logic [11:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd1311;
    return p[23:17];
  endfunction

  function automatic logic [2:0] div1000(input logic [11:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd8389;
    return p[25:23];
  endfunction

  function automatic logic [3:0] mod10(input logic [11:0] x);
    logic [11:0] r;
    r = x - 12'(div10(x)) * 12'd10;
    return r[3:0];
  endfunction

  function automatic logic [7:0] digit(input logic [11:0] x);
    return {4'h3, mod10(x)};
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
    logic [6:0]  q;
    logic [11:0] r;
    logic        leap;
    q    = div100(y);
    r    = y - 12'(q) * 12'd100;
    leap = ((y[1:0] == 2'd0) && (r != 12'd0)) || ((r == 12'd0) && (q[1:0] == 2'd0));
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      4'd2:                    return leap ? 5'd29 : 5'd28;
      default:                 return 5'd31;
    endcase
  endfunction

endpackage

// ----- rtl/acs_if.sv -----
interface acs_in_if;
  import acs_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acs_out_if;
  import acs_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acs_cfg_if;
  import acs_pkg::*;
  logic        valid;
  logic        ready;
  cfg_reg_t    index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/alarm_clock_setting_controller.sv -----
// a held word moves from input register to result register when the output can advance
// one word per cycle unless stalled; input register, one pass of logic, result register
// the result register frees the input side while a finished word waits to be taken
// reset (rst, synchronous, active high) empties both stages, restores the held time,
// alarm, brightness and timers to their start values and the registers to 200 / 700 ms
module alarm_clock_setting_controller (
  input logic      clk,
  input logic      rst,
  acs_in_if.sink   item,
  acs_out_if.source result,
  acs_cfg_if.sink  cfg
);
  import acs_pkg::*;

  logic [15:0] debounce_ms;
  logic [15:0] blink_period_ms;

  logic        s1_valid;
  in_word_t    s1;
  logic        o_valid;
  out_word_t   o;
  logic        adv;
  logic        fire;

  logic [3:0]  mode, mode_next;
  logic [11:0] year_held, year_next;
  logic [3:0]  month_held, month_next;
  logic [4:0]  date_held, date_next;
  logic [4:0]  hour_held, hour_next;
  logic [5:0]  minute_held, minute_next;
  logic [4:0]  alarm_hour, alarm_hour_next;
  logic [5:0]  alarm_minute, alarm_minute_next;
  logic [2:0]  level, level_next;
  logic        alarm_armed, alarm_armed_next;
  logic [31:0] last_press_ms, last_press_next;
  logic [31:0] last_blink_ms, last_blink_next;
  logic        blink_on, blink_on_next;

  out_word_t   res;
  logic        press_ok;
  logic        blink_due;
  logic        view;
  logic [11:0] yv;
  logic [3:0]  mv;
  logic [4:0]  dv;
  logic [4:0]  hv;
  logic [5:0]  nv;
  logic [7:0]  c0, c1, c2, c3;
  logic        hour_eq;
  logic [5:0]  diff;
  logic [3:0]  mon_mod;
  logic [5:0]  d1;
  logic [5:0]  h1;
  logic [6:0]  m1;

  assign cfg.ready    = 1'b1;
  assign adv          = !o_valid || result.ready;
  assign fire         = s1_valid && adv;
  assign item.ready   = !s1_valid || adv;
  assign result.valid = o_valid;
  assign result.data  = o;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DEBOUNCE_RST;
      blink_period_ms <= BLINK_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEBOUNCE: debounce_ms     <= cfg.data;
        REG_BLINK:    blink_period_ms <= cfg.data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1 <= item.data;
    end
    if (fire) begin
      o <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_VIEW_YEAR;
      year_held     <= YEAR_RST;
      month_held    <= MONTH_RST;
      date_held     <= DATE_RST;
      hour_held     <= HOUR_RST;
      minute_held   <= MINUTE_RST;
      alarm_hour    <= AL_HOUR_RST;
      alarm_minute  <= AL_MINUTE_RST;
      level         <= LEVEL_RST;
      alarm_armed   <= 1'b1;
      last_press_ms <= 32'd0;
      last_blink_ms <= 32'd0;
      blink_on      <= 1'b1;
    end else if (fire) begin
      mode          <= mode_next;
      year_held     <= year_next;
      month_held    <= month_next;
      date_held     <= date_next;
      hour_held     <= hour_next;
      minute_held   <= minute_next;
      alarm_hour    <= alarm_hour_next;
      alarm_minute  <= alarm_minute_next;
      level         <= level_next;
      alarm_armed   <= alarm_armed_next;
      last_press_ms <= last_press_next;
      last_blink_ms <= last_blink_next;
      blink_on      <= blink_on_next;
    end
  end

  // view values: clock reading in view modes, held values otherwise
  assign view = mode < MODE_SET_YEAR;
  assign yv   = view ? s1.clock_year   : year_held;
  assign mv   = view ? s1.clock_month  : month_held;
  assign dv   = view ? s1.clock_date   : date_held;
  assign hv   = view ? s1.clock_hour   : hour_held;
  assign nv   = view ? s1.clock_minute : minute_held;

  assign press_ok  = (s1.time_ms - last_press_ms) >= {16'd0, debounce_ms};
  assign blink_due = (s1.time_ms - last_blink_ms) > {16'd0, blink_period_ms};
  assign hour_eq   = alarm_hour == hv;
  assign diff      = (alarm_minute > nv) ? alarm_minute - nv : nv - alarm_minute;

  assign mon_mod = (month_held >= 4'd12) ? month_held - 4'd12 : month_held;
  assign d1      = {1'b0, date_held} + 6'd1;
  assign h1      = {1'b0, hour_held} + 6'd1;
  assign m1      = {1'b0, minute_held} + 7'd1;

  always_comb begin
    c0 = CHAR_SPACE;
    c1 = CHAR_SPACE;
    c2 = CHAR_SPACE;
    c3 = CHAR_SPACE;
    unique case (mode) inside
      MODE_VIEW_YEAR, MODE_SET_YEAR: begin
        c0 = digit(12'(div1000(yv)));
        c1 = digit(12'(div100(yv)));
        c2 = digit(12'(div10(yv)));
        c3 = digit(yv);
      end
      MODE_VIEW_DATE, MODE_SET_MONTH, MODE_SET_DATE: begin
        c0 = digit(12'(div10(12'(mv))));
        c1 = digit(12'(mv));
        c2 = digit(12'(div10(12'(dv))));
        c3 = digit(12'(dv));
      end
      MODE_VIEW_TIME, MODE_SET_HOUR, MODE_SET_MINUTE: begin
        c0 = digit(12'(div10(12'(hv))));
        c1 = digit(12'(hv)) | DOT_BIT;
        c2 = digit(12'(div10(12'(nv))));
        c3 = digit(12'(nv));
      end
      MODE_SET_AL_HOUR, MODE_SET_AL_MIN: begin
        c0 = digit(12'(div10(12'(alarm_hour))));
        c1 = digit(12'(alarm_hour)) | DOT_BIT;
        c2 = digit(12'(div10(12'(alarm_minute))));
        c3 = digit(12'(alarm_minute)) | DOT_BIT;
      end
      MODE_SET_LEVEL: begin
        c0 = CHAR_B;
        c1 = digit(12'(level));
      end
      default: ;
    endcase
    // blink off frame
    if (!view && !blink_on_next) begin
      unique case (mode) inside
        MODE_SET_MONTH, MODE_SET_HOUR, MODE_SET_AL_HOUR: begin
          c0 = CHAR_SPACE;
          c1 = CHAR_SPACE;
        end
        MODE_SET_DATE, MODE_SET_MINUTE: begin
          c2 = CHAR_SPACE;
          c3 = CHAR_SPACE;
        end
        MODE_SET_AL_MIN: begin
          c2 = CHAR_SPACE;
          c3 = CHAR_SPACE | DOT_BIT;
        end
        default: begin
          c0 = CHAR_SPACE;
          c1 = CHAR_SPACE;
          c2 = CHAR_SPACE;
          c3 = CHAR_SPACE;
        end
      endcase
    end
  end

  always_comb begin
    mode_next         = mode;
    year_next         = year_held;
    month_next        = month_held;
    date_next         = date_held;
    hour_next         = hour_held;
    minute_next       = minute_held;
    alarm_hour_next   = alarm_hour;
    alarm_minute_next = alarm_minute;
    level_next        = level;
    alarm_armed_next  = alarm_armed;
    last_press_next   = last_press_ms;
    last_blink_next   = last_blink_ms;
    blink_on_next     = blink_on;
    res               = '0;

    if (s1.func == FUNC_REFRESH && !view && blink_due) begin
      blink_on_next   = !blink_on;
      last_blink_next = s1.time_ms;
    end

    case (s1.func)
      FUNC_MODE: begin
        if (press_ok) begin
          last_press_next = s1.time_ms;
          if (mode == MODE_SET_LEVEL) begin
            mode_next        = MODE_VIEW_YEAR;
            alarm_armed_next = 1'b1;
            res.commit       = 1'b1;
          end else begin
            mode_next        = mode + 4'd1;
            alarm_armed_next = 1'b0;
          end
        end
      end
      FUNC_UP: begin
        if (press_ok) begin
          last_press_next = s1.time_ms;
          unique case (mode)
            MODE_SET_YEAR:
              year_next = (year_held >= YEAR_MAX) ? YEAR_MAX : year_held + 12'd1;
            MODE_SET_MONTH:
              month_next = mon_mod + 4'd1;
            MODE_SET_DATE:
              date_next = (d1 > 6'(month_len(month_held, year_held))) ? 5'd1 : d1[4:0];
            MODE_SET_HOUR:
              hour_next = (h1 >= 6'd24) ? 5'(h1 - 6'd24) : h1[4:0];
            MODE_SET_MINUTE:
              minute_next = (m1 >= 7'd60) ? 6'(m1 - 7'd60) : m1[5:0];
            MODE_SET_AL_HOUR:
              alarm_hour_next = (alarm_hour == 5'd23) ? 5'd0 : alarm_hour + 5'd1;
            MODE_SET_AL_MIN:
              alarm_minute_next = (alarm_minute >= 6'd59) ? 6'd0 : alarm_minute + 6'd1;
            MODE_SET_LEVEL:
              level_next = ((level == 3'd7) ? 3'd0 : level) + 3'd1;
            default: ;
          endcase
        end
      end
      FUNC_REFRESH: begin
        year_next   = yv;
        month_next  = mv;
        date_next   = dv;
        hour_next   = hv;
        minute_next = nv;
        res.buzz    = hour_eq && (alarm_minute == nv) && alarm_armed;
        if (!(hour_eq && diff <= 6'd2)) begin
          alarm_armed_next = 1'b1;
        end
        res.char0 = c0;
        res.char1 = c1;
        res.char2 = c2;
        res.char3 = c3;
      end
      default: ;
    endcase

    res.out_year       = year_next;
    res.out_month      = month_next;
    res.out_date       = date_next;
    res.out_hour       = hour_next;
    res.out_minute     = minute_next;
    res.out_brightness = level_next;
  end

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode <= MODE_SET_LEVEL)
    else $error("mode beyond last setting mode");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1))
    else $error("pending word lost while result stalled");

  a_commit_quiet: assert property (@(posedge clk) disable iff (rst)
    o_valid && o.commit |-> !o.buzz && o.char0 == 8'd0 && o.char3 == 8'd0)
    else $error("commit word carries display or buzz");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level != 3'd0)
    else $error("brightness level zero");

endmodule
